FILE: hw/rtl/parabolic_ease_curve_assert.svh
// Assertion helpers for the ease curve RTL.
`ifndef PARABOLIC_EASE_CURVE_ASSERT_SVH
`define PARABOLIC_EASE_CURVE_ASSERT_SVH
`ifndef SYNTHESIS
`define PEC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define PEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PEC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define PEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/pec_pkg.sv
package pec_pkg;

   localparam int FRAC_BITS = 16;
   localparam int CW        = FRAC_BITS + 1;   // Q1.F values
   localparam int IW        = FRAC_BITS + 2;   // signed Q2.F time
   localparam int OPW       = FRAC_BITS + 2;   // multiplier operands
   localparam int PW        = 2 * OPW;         // products
   localparam int NW        = PW + 1;          // numerator / remainder / divisor
   localparam int QW        = FRAC_BITS + 1;   // quotient bits
   localparam int CSR_IDX_W = 1;

   localparam logic [CW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_EASE_IN_END  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EASE_OUT_LEN = 1'b1;

   typedef enum logic [1:0] {
      SEG_RISE,
      SEG_CRUISE,
      SEG_FALL
   } seg_type;

   typedef struct packed {
      logic [CW-1:0] ease_in_end;
      logic [CW-1:0] ease_out_len;
   } cfg_type;

   typedef struct packed {
      logic [NW-1:0] rem;
      logic [NW-1:0] den;
      logic [QW-1:0] quo;
      logic          clamped;
   } div_type;

endpackage

FILE: hw/rtl/pec_req_if.sv
interface pec_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [pec_pkg::IW-1:0]     time_in;

   modport source (output valid, output time_in, input ready);
   modport sink   (input valid, input time_in, output ready);
endinterface

FILE: hw/rtl/pec_rsp_if.sv
interface pec_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [pec_pkg::CW-1:0]    position;
   logic                      was_clamped;

   modport source (output valid, output position, output was_clamped, input ready);
   modport sink   (input valid, input position, input was_clamped, output ready);
endinterface

FILE: hw/rtl/parabolic_ease_curve.sv
// Parabolic ease-in / ease-out curve, trapezoidal velocity profile.
// req_if: one signed Q2.16 time_in per transfer (valid/ready).
// rsp_if: one Q1.16 position plus was_clamped per request, in request order.
// csr_*: write-only registers, index 0 ease_in_end, index 1 ease_out_len;
//   write only while no request is in flight.
// Pipeline from the request transfer to rsp_if.valid: 4 front stages
//   (clamp, segment operands, multiply, sum) and a 17-stage restoring divider
//   that resolves one quotient bit per stage.
// Throughput: one request per cycle while rsp_if.ready stays high; the divider stages set the depth.
// Reset clears both registers to 0 and empties every stage; nothing is
//   returned for requests in flight when reset hits.
// Stall: each stage holds its item while the next one cannot take it, bubbles close
//   up, and req_if.ready drops only once all 21 stages hold an item.
module parabolic_ease_curve (
   input  logic                           clock,
   input  logic                           reset,
   pec_req_if.sink                        req_if,
   pec_rsp_if.source                      rsp_if,
   input  logic                           csr_write_en,
   input  logic [pec_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pec_pkg::CW-1:0]         csr_write_data
);

   pec_pkg::cfg_type       cfg_ff, cfg_in;
   pec_pkg::div_type       stage_data [pec_pkg::QW+1];
   logic [pec_pkg::QW:0]   stage_valid;
   logic [pec_pkg::QW:0]   stage_ready;
   pec_pkg::div_type       last;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            pec_pkg::CSR_EASE_IN_END:  cfg_in.ease_in_end  = csr_write_data;
            pec_pkg::CSR_EASE_OUT_LEN: cfg_in.ease_out_len = csr_write_data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .time_in   (req_if.time_in),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_data  (stage_data[0])
   );

   for (genvar k = 0; k < pec_pkg::QW; k++) begin : g_div
      pec_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[k]),
         .in_ready  (stage_ready[k]),
         .in_data   (stage_data[k]),
         .out_valid (stage_valid[k+1]),
         .out_ready (stage_ready[k+1]),
         .out_data  (stage_data[k+1])
      );
   end

   assign last                     = stage_data[pec_pkg::QW];
   assign stage_ready[pec_pkg::QW] = rsp_if.ready;
   assign rsp_if.valid             = stage_valid[pec_pkg::QW];
   assign rsp_if.position          = (last.quo > pec_pkg::ONE) ? pec_pkg::ONE : last.quo;
   assign rsp_if.was_clamped       = last.clamped;

endmodule

FILE: hw/rtl/pec_front.sv
`include "parabolic_ease_curve_assert.svh"

module pec_front (
   input  logic                          clock,
   input  logic                          reset,
   input  pec_pkg::cfg_type              cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [pec_pkg::IW-1:0] time_in,
   output logic                          out_valid,
   input  logic                          out_ready,
   output pec_pkg::div_type              out_data
);

   // stage 1: clamp time, effective ease points
   logic                         v1_ff;
   logic [pec_pkg::CW-1:0]       p1_ff, p1_in;
   logic [pec_pkg::CW-1:0]       ei1_ff, ei1_in;
   logic [pec_pkg::CW-1:0]       eo1_ff, eo1_in;
   logic                         clamp1_ff, clamp1_in;
   logic [pec_pkg::CW-1:0]       ei_lim;

   // stage 2: segment operands
   logic                         v2_ff;
   logic [pec_pkg::OPW-1:0]      ma1_ff, ma1_in, ma2_ff, ma2_in;
   logic [pec_pkg::OPW-1:0]      mb1_ff, mb1_in, mb2_ff, mb2_in;
   logic [pec_pkg::OPW-1:0]      md1_ff, md1_in, md2_ff, md2_in;
   logic                         clamp2_ff;
   logic [pec_pkg::OPW-1:0]      rest;
   pec_pkg::seg_type             seg;

   // stage 3: products
   logic                         v3_ff;
   logic [pec_pkg::PW-1:0]       pa_ff, pb_ff, pd_ff;
   logic                         clamp3_ff;

   // stage 4: numerator and divisor
   logic                         v4_ff;
   pec_pkg::div_type             s4_ff, s4_in;

   logic ready1, ready2, ready3, ready4;

   assign ready4   = !v4_ff || out_ready;
   assign ready3   = !v3_ff || ready4;
   assign ready2   = !v2_ff || ready3;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   always_comb begin
      ei_lim = (cfg.ease_in_end > pec_pkg::ONE) ? pec_pkg::ONE : cfg.ease_in_end;
      eo1_in = pec_pkg::ONE -
               ((cfg.ease_out_len > pec_pkg::ONE) ? pec_pkg::ONE : cfg.ease_out_len);
      ei1_in = (ei_lim > eo1_in) ? eo1_in : ei_lim;
      if (time_in[pec_pkg::IW-1]) begin
         p1_in     = '0;
         clamp1_in = 1'b1;
      end else if (time_in[pec_pkg::CW-1:0] > pec_pkg::ONE) begin
         p1_in     = pec_pkg::ONE;
         clamp1_in = 1'b1;
      end else begin
         p1_in     = time_in[pec_pkg::CW-1:0];
         clamp1_in = 1'b0;
      end
   end

   always_comb begin
      rest   = {1'b0, pec_pkg::ONE - eo1_ff};
      md1_in = {1'b0, eo1_ff} + {1'b0, pec_pkg::ONE} - {1'b0, ei1_ff};
      if (p1_ff < ei1_ff) begin
         seg = pec_pkg::SEG_RISE;
      end else if (p1_ff <= eo1_ff) begin
         seg = pec_pkg::SEG_CRUISE;
      end else begin
         seg = pec_pkg::SEG_FALL;
      end
      ma1_in = '0;
      ma2_in = '0;
      mb1_in = '0;
      mb2_in = '0;
      md2_in = '0;
      case (seg)
         pec_pkg::SEG_RISE: begin
            ma1_in = {1'b0, p1_ff};
            ma2_in = {1'b0, p1_ff};
            md2_in = {1'b0, ei1_ff};
         end
         pec_pkg::SEG_CRUISE: begin
            ma1_in = {p1_ff, 1'b0} - {1'b0, ei1_ff};
            ma2_in = pec_pkg::OPW'(1);
            md2_in = pec_pkg::OPW'(1);
         end
         pec_pkg::SEG_FALL: begin
            ma1_in = {eo1_ff, 1'b0} - {1'b0, ei1_ff};
            ma2_in = rest;
            mb1_in = {1'b0, p1_ff - eo1_ff};
            mb2_in = {pec_pkg::ONE, 1'b0} - {1'b0, p1_ff} - {1'b0, eo1_ff};
            md2_in = rest;
         end
         default: begin
            ma1_in = '0;
         end
      endcase
   end

   always_comb begin
      s4_in.rem     = {1'b0, pa_ff} + {1'b0, pb_ff};
      s4_in.den     = {1'b0, pd_ff};
      s4_in.quo     = '0;
      s4_in.clamped = clamp3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= in_valid;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
         if (ready4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         p1_ff     <= p1_in;
         ei1_ff    <= ei1_in;
         eo1_ff    <= eo1_in;
         clamp1_ff <= clamp1_in;
      end
      if (ready2) begin
         ma1_ff    <= ma1_in;
         ma2_ff    <= ma2_in;
         mb1_ff    <= mb1_in;
         mb2_ff    <= mb2_in;
         md1_ff    <= md1_in;
         md2_ff    <= md2_in;
         clamp2_ff <= clamp1_ff;
      end
      if (ready3) begin
         pa_ff     <= ma1_ff * ma2_ff;
         pb_ff     <= mb1_ff * mb2_ff;
         pd_ff     <= md1_ff * md2_ff;
         clamp3_ff <= clamp2_ff;
      end
      if (ready4) begin
         s4_ff <= s4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = s4_ff;

   `PEC_ASSERT_IMPL(a_num_le_den, clock, reset, out_valid, out_data.rem <= out_data.den, "numerator above divisor")

endmodule

FILE: hw/rtl/pec_div_stage.sv
`include "parabolic_ease_curve_assert.svh"

module pec_div_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  pec_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output pec_pkg::div_type out_data
);

   logic                    valid_ff;
   pec_pkg::div_type        data_ff, data_in;
   logic [pec_pkg::NW:0]    diff;
   logic                    ge;
   logic [pec_pkg::NW-1:0]  rem_sel;

   assign in_ready = !valid_ff || out_ready;

   // one restoring step: quotient bit in, remainder doubled for the next bit
   always_comb begin
      diff         = {1'b0, in_data.rem} - {1'b0, in_data.den};
      ge           = !diff[pec_pkg::NW];
      rem_sel      = ge ? diff[pec_pkg::NW-1:0] : in_data.rem;
      data_in.rem  = {rem_sel[pec_pkg::NW-2:0], 1'b0};
      data_in.den  = in_data.den;
      data_in.quo  = {in_data.quo[pec_pkg::QW-2:0], ge};
      data_in.clamped = in_data.clamped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   `PEC_ASSERT_IMPL(a_rem_bound, clock, reset, valid_ff, data_ff.rem < {data_ff.den[pec_pkg::NW-2:0], 1'b0}, "remainder out of bound")
   `PEC_ASSERT_NEXT(a_den_kept, clock, reset, in_valid && in_ready, data_ff.den == $past(in_data.den), "divisor changed in stage")
   `PEC_ASSERT_NEXT(a_quo_shift, clock, reset, in_valid && in_ready, data_ff.quo[pec_pkg::QW-1:1] == $past(in_data.quo[pec_pkg::QW-2:0]), "quotient bits lost")

endmodule

FILE: tb/sv/testbench.sv
module testbench;

   localparam int LATENCY     = 21;
   localparam int HOLD_CYCLES = 200;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 75;

   typedef struct packed {
      logic [pec_pkg::CW-1:0] position;
      logic                   was_clamped;
   } ease_result_type;

   logic clock;
   logic reset;
   logic                          csr_write_en;
   logic [pec_pkg::CSR_IDX_W-1:0] csr_index;
   logic [pec_pkg::CW-1:0]        csr_write_data;

   pec_req_if req_if();
   pec_rsp_if rsp_if();

   parabolic_ease_curve u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   logic [pec_pkg::CW-1:0] cfg_ease_in_end;
   logic [pec_pkg::CW-1:0] cfg_ease_out_len;

   logic signed [pec_pkg::IW-1:0] pending_times[$];
   ease_result_type               expected_positions[$];

   int send_idle_pct;
   int recv_stall_pct;
   int holds_asked;
   int holds_served;
   int hold_left;
   int mismatch_count;
   int result_count;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // effective ease-in end and ease-out start after limiting
   function automatic void segment_bounds(output longint unsigned ei,
                                          output longint unsigned eo);
      longint unsigned one;
      longint unsigned len;
      one = 64'(pec_pkg::ONE);
      ei  = 64'(cfg_ease_in_end);
      len = 64'(cfg_ease_out_len);
      if (ei > one) ei = one;
      if (len > one) len = one;
      eo = one - len;
      if (ei > eo) ei = eo;
   endfunction

   function automatic ease_result_type ease_position(logic signed [pec_pkg::IW-1:0] t);
      longint unsigned one;
      longint unsigned ei;
      longint unsigned eo;
      longint unsigned p;
      longint unsigned scale;
      longint unsigned rest;
      longint unsigned num;
      longint unsigned den;
      longint unsigned pos;
      ease_result_type r;
      one = 64'(pec_pkg::ONE);
      segment_bounds(ei, eo);
      r.was_clamped = 1'b0;
      if (t < 0) begin
         p = 0;
         r.was_clamped = 1'b1;
      end else if (longint'(t) > longint'(one)) begin
         p = one;
         r.was_clamped = 1'b1;
      end else begin
         p = longint'(t);
      end
      scale = eo + one - ei;
      if (p < ei) begin
         num = p * p * one;
         den = scale * ei;
      end else if (p <= eo) begin
         num = (2 * p - ei) * one;
         den = scale;
      end else begin
         rest = one - eo;
         num  = ((2 * eo - ei) * rest + (p - eo) * (2 * one - p - eo)) * one;
         den  = scale * rest;
      end
      pos = (den == 0) ? 0 : num / den;
      if (pos > one) pos = one;
      r.position = pos[pec_pkg::CW-1:0];
      return r;
   endfunction

   function automatic logic signed [pec_pkg::IW-1:0] pick_time();
      longint unsigned ei;
      longint unsigned eo;
      longint unsigned base;
      int sel;
      segment_bounds(ei, eo);
      sel = $urandom_range(99);
      if (sel < 70) return pec_pkg::IW'($urandom_range(0, 32'(pec_pkg::ONE)));
      if (sel < 85) begin
         case ($urandom_range(3))
            0: base = ei;
            1: base = eo;
            2: base = 0;
            default: base = 64'(pec_pkg::ONE);
         endcase
         return pec_pkg::IW'(longint'(base) + $urandom_range(0, 6) - 3);
      end
      return pec_pkg::IW'($urandom());
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      mismatch_count++;
      $display("mismatch %s on result %0d: got %0d, expected %0d",
               field, result_count, got, want);
   endtask

   task automatic write_reg(logic [pec_pkg::CSR_IDX_W-1:0] idx,
                            logic [pec_pkg::CW-1:0] value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      if (idx == pec_pkg::CSR_EASE_IN_END) cfg_ease_in_end = value;
      else cfg_ease_out_len = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_profile(logic [pec_pkg::CW-1:0] in_end,
                              logic [pec_pkg::CW-1:0] out_len);
      write_reg(pec_pkg::CSR_EASE_IN_END, in_end);
      write_reg(pec_pkg::CSR_EASE_OUT_LEN, out_len);
   endtask

   task automatic drain_results();
      while (pending_times.size() != 0 || req_if.valid || expected_positions.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) expected_positions.push_back(ease_position(req_if.time_in));
         if (pending_times.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_if.valid   <= 1'b1;
            req_if.time_in <= pending_times.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result monitor and receiver backpressure
   always @(posedge clock) begin
      ease_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            result_count++;
            if (expected_positions.size() == 0) begin
               report_mismatch("unexpected transfer", longint'(rsp_if.position), -1);
            end else begin
               want = expected_positions.pop_front();
               if (rsp_if.position !== want.position)
                  report_mismatch("position", longint'(rsp_if.position),
                                  longint'(want.position));
               if (rsp_if.was_clamped !== want.was_clamped)
                  report_mismatch("was_clamped", longint'(rsp_if.was_clamped),
                                  longint'(want.was_clamped));
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
         else quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic signed [pec_pkg::IW-1:0] directed[] = '{
         -18'sd131072, 18'sd131071, -18'sd1, 18'sd0, 18'sd1, 18'sd2,
         18'sd16383, 18'sd16384, 18'sd16385, 18'sd32768, 18'sd49151,
         18'sd49152, 18'sd49153, 18'sd65535, 18'sd65536, 18'sd65537};
      logic [pec_pkg::CW-1:0] in_ends[PHASES]  = '{0, 65536, 131071, 40000, 65536, 0, 0, 0};
      logic [pec_pkg::CW-1:0] out_lens[PHASES] = '{0, 65536, 131071, 40000, 0, 65536, 0, 0};
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.time_in   = '0;
      rsp_if.ready     = 1'b0;
      csr_write_en     = 1'b0;
      csr_index        = pec_pkg::CSR_EASE_IN_END;
      csr_write_data   = '0;
      cfg_ease_in_end  = '0;
      cfg_ease_out_len = '0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      holds_asked      = 0;
      holds_served     = 0;
      hold_left        = 0;
      mismatch_count   = 0;
      result_count     = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset profile is a straight line
      @(negedge clock);
      pending_times.push_back(18'sd0);
      pending_times.push_back(18'sd32768);
      pending_times.push_back(18'sd65536);
      drain_results();

      set_profile(16384, 16384);
      @(negedge clock);
      foreach (directed[i]) pending_times.push_back(directed[i]);
      drain_results();

      in_ends[6]  = pec_pkg::CW'($urandom_range(0, 32'(pec_pkg::ONE)));
      out_lens[6] = pec_pkg::CW'($urandom_range(0, 32'(pec_pkg::ONE)));
      in_ends[7]  = pec_pkg::CW'($urandom_range(0, 2 ** pec_pkg::CW - 1));
      out_lens[7] = pec_pkg::CW'($urandom_range(0, 2 ** pec_pkg::CW - 1));
      for (int ph = 0; ph < PHASES; ph++) begin
         set_profile(in_ends[ph], out_lens[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         // long receiver hold-off while the sender keeps offering
         if (ph == 4) holds_asked++;
         @(negedge clock);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender waits for every outstanding result halfway through
            if (ph == 1 && n == PHASE_ITEMS / 2) begin
               drain_results();
               @(negedge clock);
            end
            pending_times.push_back(pick_time());
         end
         drain_results();
      end

      if (mismatch_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
